### src/glyph_text_renderer_defines.svh
// glyph_text_renderer_defines.svh: assertion macros for the glyph text renderer RTL.
// Needs a clk and an active-low arst_n in the scope of each use.
`ifndef GLYPH_TEXT_RENDERER_DEFINES_SVH
`define GLYPH_TEXT_RENDERER_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset
`define GTR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition must never be true outside reset
`define GTR_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define GTR_ASSERT(lbl, prop, msg)
`define GTR_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

### src/gtr_pkg.sv
// gtr_pkg.sv: geometry constants, types, mode codes, queue command and the 5x7 font
// for the glyph text renderer. No dependencies.
`timescale 1ns / 1ps

package gtr_pkg;

	// Frame store geometry
	localparam int COLUMNS = 128;
	localparam int PAGES   = 8;
	localparam int DEPTH   = COLUMNS * PAGES;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int COL_W   = $clog2(COLUMNS);
	localparam int CUR_W   = $clog2(COLUMNS + 1);
	localparam int PAGE_W  = (PAGES > 1) ? $clog2(PAGES) : 1;

	// Compare widths wide enough for the input fields plus small offsets
	localparam int CMP_W     = $clog2(COLUMNS) + 4;
	localparam int ROW_CMP_W = $clog2(8 * PAGES) + 4;
	localparam int PG_CMP_W  = $clog2(PAGES) + 4;

	// Glyph geometry
	localparam int GLYPH_COLS = 5;
	localparam int CELL_ADV   = 6;
	localparam int GLYPH_W    = 8 * GLYPH_COLS;

	// Command queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;

	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [COL_W-1:0]     col_t;
	typedef logic [CUR_W-1:0]     cur_t;
	typedef logic [PAGE_W-1:0]    page_t;
	typedef logic [CMP_W-1:0]     cmp_t;
	typedef logic [ROW_CMP_W-1:0] row_cmp_t;
	typedef logic [PG_CMP_W-1:0]  pg_cmp_t;
	typedef logic [GLYPH_W-1:0]   glyph_t;
	typedef logic [6:0]           glyph_idx_t;
	typedef logic [2:0]           kidx_t;
	typedef logic [PTR_W-1:0]     ptr_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [2:0]           mode_code_t;

	// Character codes
	localparam logic [7:0] FIRST_CODE = 8'd32;
	localparam logic [7:0] LAST_CODE  = 8'd128;
	localparam logic [7:0] NEWLINE    = 8'd10;

	// Request modes
	localparam mode_code_t MODE_PUT      = 3'd0;
	localparam mode_code_t MODE_SET_COL  = 3'd1;
	localparam mode_code_t MODE_SET_PAGE = 3'd2;
	localparam mode_code_t MODE_PLACE    = 3'd3;
	localparam mode_code_t MODE_READ     = 3'd4;

	// Work handed from the front end to the back end
	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_ERASE = 2'd1,
		OP_DRAW  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       status;
		logic [7:0] echo;
		page_t      page;
		cur_t       col;
		glyph_t     glyph;
		logic [2:0] shift;
		logic       split;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// 5x7 font, codes 32 to 128; column 0 in the top byte, bit 0 is the top pixel
	function automatic glyph_t font_glyph(input glyph_idx_t idx);
		glyph_t g;
		case (idx)
			7'd0:  g = 40'h00_00_00_00_00;
			7'd1:  g = 40'h00_00_5F_00_00;
			7'd2:  g = 40'h00_07_00_07_00;
			7'd3:  g = 40'h14_7F_14_7F_14;
			7'd4:  g = 40'h24_2A_7F_2A_12;
			7'd5:  g = 40'h23_13_08_64_62;
			7'd6:  g = 40'h36_49_55_22_50;
			7'd7:  g = 40'h00_05_03_00_00;
			7'd8:  g = 40'h00_1C_22_41_00;
			7'd9:  g = 40'h00_41_22_1C_00;
			7'd10: g = 40'h08_2A_1C_2A_08;
			7'd11: g = 40'h08_08_3E_08_08;
			7'd12: g = 40'h00_50_30_00_00;
			7'd13: g = 40'h08_08_08_08_08;
			7'd14: g = 40'h00_60_60_00_00;
			7'd15: g = 40'h20_10_08_04_02;
			7'd16: g = 40'h3E_51_49_45_3E;
			7'd17: g = 40'h00_42_7F_40_00;
			7'd18: g = 40'h42_61_51_49_46;
			7'd19: g = 40'h21_41_45_4B_31;
			7'd20: g = 40'h18_14_12_7F_10;
			7'd21: g = 40'h27_45_45_45_39;
			7'd22: g = 40'h3C_4A_49_49_30;
			7'd23: g = 40'h01_71_09_05_03;
			7'd24: g = 40'h36_49_49_49_36;
			7'd25: g = 40'h06_49_49_29_1E;
			7'd26: g = 40'h00_36_36_00_00;
			7'd27: g = 40'h00_56_36_00_00;
			7'd28: g = 40'h00_08_14_22_41;
			7'd29: g = 40'h14_14_14_14_14;
			7'd30: g = 40'h41_22_14_08_00;
			7'd31: g = 40'h02_01_51_09_06;
			7'd32: g = 40'h32_49_79_41_3E;
			7'd33: g = 40'h7E_11_11_11_7E;
			7'd34: g = 40'h7F_49_49_49_36;
			7'd35: g = 40'h3E_41_41_41_22;
			7'd36: g = 40'h7F_41_41_22_1C;
			7'd37: g = 40'h7F_49_49_49_41;
			7'd38: g = 40'h7F_09_09_01_01;
			7'd39: g = 40'h3E_41_41_51_32;
			7'd40: g = 40'h7F_08_08_08_7F;
			7'd41: g = 40'h00_41_7F_41_00;
			7'd42: g = 40'h20_40_41_3F_01;
			7'd43: g = 40'h7F_08_14_22_41;
			7'd44: g = 40'h7F_40_40_40_40;
			7'd45: g = 40'h7F_02_04_02_7F;
			7'd46: g = 40'h7F_04_08_10_7F;
			7'd47: g = 40'h3E_41_41_41_3E;
			7'd48: g = 40'h7F_09_09_09_06;
			7'd49: g = 40'h3E_41_51_21_5E;
			7'd50: g = 40'h7F_09_19_29_46;
			7'd51: g = 40'h46_49_49_49_31;
			7'd52: g = 40'h01_01_7F_01_01;
			7'd53: g = 40'h3F_40_40_40_3F;
			7'd54: g = 40'h1F_20_40_20_1F;
			7'd55: g = 40'h7F_20_18_20_7F;
			7'd56: g = 40'h63_14_08_14_63;
			7'd57: g = 40'h03_04_78_04_03;
			7'd58: g = 40'h61_51_49_45_43;
			7'd59: g = 40'h00_00_7F_41_41;
			7'd60: g = 40'h02_04_08_10_20;
			7'd61: g = 40'h41_41_7F_00_00;
			7'd62: g = 40'h04_02_01_02_04;
			7'd63: g = 40'h40_40_40_40_40;
			7'd64: g = 40'h00_01_02_04_00;
			7'd65: g = 40'h20_54_54_54_78;
			7'd66: g = 40'h7F_48_44_44_38;
			7'd67: g = 40'h38_44_44_44_20;
			7'd68: g = 40'h38_44_44_48_7F;
			7'd69: g = 40'h38_54_54_54_18;
			7'd70: g = 40'h08_7E_09_01_02;
			7'd71: g = 40'h08_14_54_54_3C;
			7'd72: g = 40'h7F_08_04_04_78;
			7'd73: g = 40'h00_44_7D_40_00;
			7'd74: g = 40'h20_40_44_3D_00;
			7'd75: g = 40'h00_7F_10_28_44;
			7'd76: g = 40'h00_41_7F_40_00;
			7'd77: g = 40'h7C_04_18_04_78;
			7'd78: g = 40'h7C_08_04_04_78;
			7'd79: g = 40'h38_44_44_44_38;
			7'd80: g = 40'h7C_14_14_14_08;
			7'd81: g = 40'h08_14_14_18_7C;
			7'd82: g = 40'h7C_08_04_04_08;
			7'd83: g = 40'h48_54_54_54_20;
			7'd84: g = 40'h04_3F_44_40_20;
			7'd85: g = 40'h3C_40_40_20_7C;
			7'd86: g = 40'h1C_20_40_20_1C;
			7'd87: g = 40'h3C_40_30_40_3C;
			7'd88: g = 40'h44_28_10_28_44;
			7'd89: g = 40'h0C_50_50_50_3C;
			7'd90: g = 40'h44_64_54_4C_44;
			7'd91: g = 40'h00_08_36_41_00;
			7'd92: g = 40'h00_00_7F_00_00;
			7'd93: g = 40'h00_41_36_08_00;
			7'd94: g = 40'h08_08_2A_1C_08;
			7'd95: g = 40'h08_1C_2A_08_08;
			7'd96: g = 40'h06_1E_1C_1E_06;
			default: g = '0;
		endcase
		return g;
	endfunction

endpackage

### src/gtr_in_if.sv
// gtr_in_if.sv: request channel of the glyph text renderer (valid/ready plus fields).
// No dependencies.
`timescale 1ns / 1ps

interface gtr_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] mode;
	logic [7:0] code;
	logic [6:0] column;
	logic [3:0] page_index;
	logic [5:0] pixel_row;

	modport source (
		output valid, mode, code, column, page_index, pixel_row,
		input  ready
	);
	modport sink (
		input  valid, mode, code, column, page_index, pixel_row,
		output ready
	);
endinterface

### src/gtr_out_if.sv
// gtr_out_if.sv: result channel of the glyph text renderer (valid/ready plus fields).
// No dependencies.
`timescale 1ns / 1ps

interface gtr_out_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic [7:0] echo_code;
	logic [7:0] read_byte;

	modport source (
		output valid, status, echo_code, read_byte,
		input  ready
	);
	modport sink (
		input  valid, status, echo_code, read_byte,
		output ready
	);
endinterface

### src/gtr_front.sv
// gtr_front.sv: request front end; owns the text cursor, range-checks each request
// and turns it into a queue command. Uses gtr_pkg, gtr_in_if and the assertion macros.
`timescale 1ns / 1ps
`include "glyph_text_renderer_defines.svh"

module gtr_front (
	input  logic                clk,
	input  logic                arst_n,
	gtr_in_if.sink              cmd,
	input  logic                clearing,
	input  gtr_pkg::fifo_stat_t fstat,
	output logic                push,
	output gtr_pkg::cmd_t       push_cmd
);

	gtr_pkg::page_t  cursor_page_q;
	gtr_pkg::cur_t   cursor_column_q;
	gtr_pkg::page_t  page_d;
	gtr_pkg::cur_t   col_d;
	gtr_pkg::page_t  cur_next_page;
	gtr_pkg::page_t  draw_page;
	gtr_pkg::cur_t   draw_col;
	gtr_pkg::glyph_t glyph;
	logic            has_glyph;
	logic            wrap;
	logic            set_col_ok;
	logic            page_ok;
	logic            read_col_ok;
	logic            row_ok;

	// Page after p, wrapping from the last page to the first
	function automatic gtr_pkg::page_t next_page(input gtr_pkg::page_t p);
		gtr_pkg::page_t n;
		if (p == gtr_pkg::page_t'(gtr_pkg::PAGES - 1))
			n = '0;
		else
			n = p + gtr_pkg::page_t'(1);
		return n;
	endfunction

	// Transfer when the back end is not sweeping the store and the queue has room
	assign cmd.ready = !clearing && !fstat.full;
	assign push      = cmd.valid && cmd.ready;

	// Range checks
	assign has_glyph   = (cmd.code >= gtr_pkg::FIRST_CODE) && (cmd.code <= gtr_pkg::LAST_CODE);
	assign set_col_ok  = (gtr_pkg::cmp_t'(cmd.column) + gtr_pkg::cmp_t'(gtr_pkg::GLYPH_COLS))
		< gtr_pkg::cmp_t'(gtr_pkg::COLUMNS);
	assign read_col_ok = gtr_pkg::cmp_t'(cmd.column) < gtr_pkg::cmp_t'(gtr_pkg::COLUMNS);
	assign page_ok     = gtr_pkg::pg_cmp_t'(cmd.page_index) < gtr_pkg::pg_cmp_t'(gtr_pkg::PAGES);
	assign row_ok      = (gtr_pkg::row_cmp_t'(cmd.pixel_row) + gtr_pkg::row_cmp_t'(7))
		< gtr_pkg::row_cmp_t'(8 * gtr_pkg::PAGES);

	// Cursor glyph placement, with wrap to the next line at the right edge
	assign cur_next_page = next_page(cursor_page_q);
	assign wrap          = (gtr_pkg::cmp_t'(cursor_column_q) + gtr_pkg::cmp_t'(gtr_pkg::GLYPH_COLS))
		>= gtr_pkg::cmp_t'(gtr_pkg::COLUMNS);
	assign draw_page     = wrap ? cur_next_page : cursor_page_q;
	assign draw_col      = wrap ? '0 : cursor_column_q;

	assign glyph = gtr_pkg::font_glyph(gtr_pkg::glyph_idx_t'(cmd.code - gtr_pkg::FIRST_CODE));

	// Request decode: queue command and next cursor
	always_comb begin
		push_cmd        = '0;
		push_cmd.op     = gtr_pkg::OP_NONE;
		push_cmd.status = 1'b1;
		push_cmd.glyph  = glyph;
		page_d          = cursor_page_q;
		col_d           = cursor_column_q;
		unique case (cmd.mode)
			gtr_pkg::MODE_PUT: begin
				if (cmd.code == gtr_pkg::NEWLINE) begin
					push_cmd.op     = gtr_pkg::OP_ERASE;
					push_cmd.status = 1'b0;
					push_cmd.page   = cursor_page_q;
					push_cmd.col    = cursor_column_q;
					page_d          = cur_next_page;
					col_d           = '0;
				end else if (has_glyph) begin
					push_cmd.op     = gtr_pkg::OP_DRAW;
					push_cmd.status = 1'b0;
					push_cmd.echo   = cmd.code;
					push_cmd.page   = draw_page;
					push_cmd.col    = draw_col;
					page_d          = draw_page;
					col_d           = draw_col + gtr_pkg::cur_t'(gtr_pkg::CELL_ADV);
				end
			end
			gtr_pkg::MODE_SET_COL: begin
				if (set_col_ok) begin
					push_cmd.status = 1'b0;
					col_d           = gtr_pkg::cur_t'(cmd.column);
				end
			end
			gtr_pkg::MODE_SET_PAGE: begin
				if (page_ok) begin
					push_cmd.status = 1'b0;
					page_d          = gtr_pkg::page_t'(cmd.page_index);
				end
			end
			gtr_pkg::MODE_PLACE: begin
				if (row_ok && set_col_ok && has_glyph) begin
					push_cmd.op     = gtr_pkg::OP_DRAW;
					push_cmd.status = 1'b0;
					push_cmd.echo   = cmd.code;
					push_cmd.page   = gtr_pkg::page_t'(cmd.pixel_row[5:3]);
					push_cmd.col    = gtr_pkg::cur_t'(cmd.column);
					push_cmd.shift  = cmd.pixel_row[2:0];
					push_cmd.split  = |cmd.pixel_row[2:0];
				end
			end
			gtr_pkg::MODE_READ: begin
				if (page_ok && read_col_ok) begin
					push_cmd.op     = gtr_pkg::OP_READ;
					push_cmd.status = 1'b0;
					push_cmd.page   = gtr_pkg::page_t'(cmd.page_index);
					push_cmd.col    = gtr_pkg::cur_t'(cmd.column);
				end
			end
			default: ;
		endcase
	end

	// Text cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_page_q   <= '0;
			cursor_column_q <= '0;
		end else if (push) begin
			cursor_page_q   <= page_d;
			cursor_column_q <= col_d;
		end
	end

	`GTR_ASSERT(a_cursor_col_range, cursor_column_q <= gtr_pkg::cur_t'(gtr_pkg::COLUMNS), "cursor column past right edge")
	`GTR_ASSERT(a_cursor_page_range, cursor_page_q <= gtr_pkg::page_t'(gtr_pkg::PAGES - 1), "cursor page out of range")

endmodule

### src/gtr_cmd_fifo.sv
// gtr_cmd_fifo.sv: short first-word-fall-through command queue between front and back.
// Uses gtr_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "glyph_text_renderer_defines.svh"

module gtr_cmd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gtr_pkg::cmd_t       push_cmd,
	input  logic                pop,
	output gtr_pkg::cmd_t       pop_cmd,
	output gtr_pkg::fifo_stat_t stat
);

	gtr_pkg::cmd_t  slots_q [gtr_pkg::FIFO_DEPTH];
	gtr_pkg::ptr_t  wr_ptr_q;
	gtr_pkg::ptr_t  rd_ptr_q;
	gtr_pkg::cnt_t  count_q;

	assign stat.full  = (count_q == gtr_pkg::cnt_t'(gtr_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_cmd    = slots_q[rd_ptr_q];

	// Storage slots
	always_ff @(posedge clk) begin
		if (push)
			slots_q[wr_ptr_q] <= push_cmd;
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + gtr_pkg::ptr_t'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + gtr_pkg::ptr_t'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + gtr_pkg::cnt_t'(1);
				2'b01:   count_q <= count_q - gtr_pkg::cnt_t'(1);
				default: ;
			endcase
		end
	end

	`GTR_ASSERT_NEVER(a_push_when_full, push && stat.full, "command pushed into a full queue")
	`GTR_ASSERT_NEVER(a_pop_when_empty, pop && stat.empty, "command popped from an empty queue")

endmodule

### src/gtr_back.sv
// gtr_back.sv: back end; owns the frame store, sweeps it clear after reset, executes
// erase, glyph read-modify-write and byte read commands, and holds the result register.
// Uses gtr_pkg, gtr_out_if and the assertion macros.
`timescale 1ns / 1ps
`include "glyph_text_renderer_defines.svh"

module gtr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  gtr_pkg::cmd_t       pop_cmd,
	input  gtr_pkg::fifo_stat_t stat,
	output logic                pop,
	output logic                clearing,
	gtr_out_if.source           rsp
);

	typedef enum logic [5:0] {
		B_CLEAR = 6'b000001,
		B_IDLE  = 6'b000010,
		B_RD    = 6'b000100,
		B_WR    = 6'b001000,
		B_ERASE = 6'b010000,
		B_DONE  = 6'b100000
	} bstate_t;

	bstate_t          state_q;
	gtr_pkg::addr_t   clr_addr_q;
	logic             out_valid_q;

	// Working copy of the current command
	gtr_pkg::op_t     op_q;
	gtr_pkg::page_t   page_q;
	gtr_pkg::cur_t    col_q;
	gtr_pkg::glyph_t  glyph_q;
	logic [2:0]       shift_q;
	logic             split_q;
	gtr_pkg::kidx_t   k_q;
	logic             half_q;
	logic             status_q;
	logic [7:0]       echo_q;
	logic [7:0]       rbyte_q;

	// Result register
	logic             out_status_q;
	logic [7:0]       out_echo_q;
	logic [7:0]       out_byte_q;

	// Frame store
	logic [7:0]       store [gtr_pkg::DEPTH];
	logic [7:0]       rdata_q;
	logic             we;
	gtr_pkg::addr_t   waddr;
	logic [7:0]       wdata;

	gtr_pkg::page_t   acc_page;
	gtr_pkg::col_t    acc_col;
	gtr_pkg::addr_t   acc_addr;
	logic [7:0]       gcol;
	logic [15:0]      gshift;
	logic [7:0]       draw_byte;
	logic             load;

	function automatic gtr_pkg::addr_t store_addr(input gtr_pkg::page_t pg,
	                                              input gtr_pkg::col_t c);
		return gtr_pkg::addr_t'(pg) * gtr_pkg::addr_t'(gtr_pkg::COLUMNS) + gtr_pkg::addr_t'(c);
	endfunction

	assign pop      = (state_q == B_IDLE) && !stat.empty;
	assign clearing = (state_q == B_CLEAR);
	assign load     = !out_valid_q || rsp.ready;

	// Byte under work: lower page for the second half of a split glyph column
	assign acc_page = half_q ? page_q + gtr_pkg::page_t'(1) : page_q;
	assign acc_col  = gtr_pkg::col_t'(col_q + gtr_pkg::cur_t'(k_q));
	assign acc_addr = store_addr(acc_page, acc_col);

	// Glyph column k, shifted down to its pixel row
	always_comb begin
		case (k_q)
			3'd0:    gcol = glyph_q[39:32];
			3'd1:    gcol = glyph_q[31:24];
			3'd2:    gcol = glyph_q[23:16];
			3'd3:    gcol = glyph_q[15:8];
			3'd4:    gcol = glyph_q[7:0];
			default: gcol = '0;
		endcase
	end
	assign gshift    = {8'h00, gcol} << shift_q;
	assign draw_byte = half_q ? gshift[15:8] : gshift[7:0];

	// Store write port
	always_comb begin
		we    = 1'b0;
		waddr = acc_addr;
		wdata = '0;
		unique case (state_q)
			B_CLEAR: begin
				we    = 1'b1;
				waddr = clr_addr_q;
			end
			B_ERASE: we = 1'b1;
			B_WR: begin
				we    = (op_q == gtr_pkg::OP_DRAW);
				wdata = rdata_q | draw_byte;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			store[waddr] <= wdata;
		rdata_q <= store[acc_addr];
	end

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLEAR;
			clr_addr_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				B_CLEAR: begin
					clr_addr_q <= clr_addr_q + gtr_pkg::addr_t'(1);
					if (clr_addr_q == gtr_pkg::addr_t'(gtr_pkg::DEPTH - 1))
						state_q <= B_IDLE;
				end
				B_IDLE: begin
					if (!stat.empty) begin
						unique case (pop_cmd.op)
							gtr_pkg::OP_NONE: state_q <= B_DONE;
							gtr_pkg::OP_ERASE: begin
								if (pop_cmd.col >= gtr_pkg::cur_t'(gtr_pkg::COLUMNS))
									state_q <= B_DONE;
								else
									state_q <= B_ERASE;
							end
							gtr_pkg::OP_DRAW: state_q <= B_RD;
							gtr_pkg::OP_READ: state_q <= B_RD;
							default:          state_q <= B_DONE;
						endcase
					end
				end
				B_RD: state_q <= B_WR;
				B_WR: begin
					if (op_q == gtr_pkg::OP_READ)
						state_q <= B_DONE;
					else if (!half_q && split_q)
						state_q <= B_RD;
					else if (k_q == gtr_pkg::kidx_t'(gtr_pkg::GLYPH_COLS - 1))
						state_q <= B_DONE;
					else
						state_q <= B_RD;
				end
				B_ERASE: begin
					if (col_q == gtr_pkg::cur_t'(gtr_pkg::COLUMNS - 1))
						state_q <= B_DONE;
				end
				B_DONE: begin
					if (load) begin
						out_valid_q <= 1'b1;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Command datapath and result register
	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				if (!stat.empty) begin
					op_q     <= pop_cmd.op;
					page_q   <= pop_cmd.page;
					col_q    <= pop_cmd.col;
					glyph_q  <= pop_cmd.glyph;
					shift_q  <= pop_cmd.shift;
					split_q  <= pop_cmd.split;
					status_q <= pop_cmd.status;
					echo_q   <= pop_cmd.echo;
					k_q      <= '0;
					half_q   <= 1'b0;
					rbyte_q  <= '0;
				end
			end
			B_WR: begin
				if (op_q == gtr_pkg::OP_READ) begin
					rbyte_q <= rdata_q;
				end else if (!half_q && split_q) begin
					half_q <= 1'b1;
				end else begin
					half_q <= 1'b0;
					k_q    <= k_q + gtr_pkg::kidx_t'(1);
				end
			end
			B_ERASE: col_q <= col_q + gtr_pkg::cur_t'(1);
			B_DONE: begin
				if (load) begin
					out_status_q <= status_q;
					out_echo_q   <= echo_q;
					out_byte_q   <= rbyte_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.echo_code = out_echo_q;
	assign rsp.read_byte = out_byte_q;

	`GTR_ASSERT(a_no_result_in_clear, (state_q == B_CLEAR) |-> !out_valid_q, "result offered during store sweep")
	`GTR_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == B_DONE), "result loaded outside completion")
	`GTR_ASSERT(a_split_page_range, (state_q == B_WR && op_q == gtr_pkg::OP_DRAW && half_q) |-> (page_q != gtr_pkg::page_t'(gtr_pkg::PAGES - 1)), "split glyph runs past last page")

endmodule

### src/glyph_text_renderer.sv
// Glyph text renderer: 5x7 font text drawn into a page-organized monochrome frame store.
// Requests arrive on cmd (gtr_in_if), results leave on rsp (gtr_out_if), one per request,
// in request order. A transfer happens on a rising clk edge with valid and ready high.
// Structure: gtr_front checks requests and keeps the text cursor, gtr_cmd_fifo holds up
// to four commands, gtr_back runs them against the frame store.
// Reset (arst_n low) clears the cursor and starts a sweep that writes zero to every
// store byte, one byte a cycle, COLUMNS*PAGES (1024) bytes in all. cmd.ready stays low meanwhile.
// Work per request in the back end, set by the store's one read and one write port:
//   cursor/page set or rejected request: no store access, byte read: one store read,
//   glyph on a page boundary: five read-modify-writes, one per glyph column,
//   glyph at any other pixel row: ten read-modify-writes (two per column),
//   newline: one erase write per column from the cursor column to the right edge.
// A result waits on that work and on any work queued ahead of it.
// Results sit in an output register; while rsp.ready is low the back end finishes the
// current command and holds, and the front end keeps taking requests until the queue fills.
// Uses gtr_pkg, gtr_in_if, gtr_out_if, gtr_front, gtr_cmd_fifo and gtr_back.
`timescale 1ns / 1ps

module glyph_text_renderer (
	input  logic      clk,
	input  logic      arst_n,
	gtr_in_if.sink    cmd,
	gtr_out_if.source rsp
);

	gtr_pkg::cmd_t       push_cmd;
	gtr_pkg::cmd_t       pop_cmd;
	gtr_pkg::fifo_stat_t fstat;
	logic                push;
	logic                pop;
	logic                clearing;

	gtr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.clearing (clearing),
		.fstat    (fstat),
		.push     (push),
		.push_cmd (push_cmd)
	);

	gtr_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.stat     (fstat)
	);

	gtr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_cmd  (pop_cmd),
		.stat     (fstat),
		.pop      (pop),
		.clearing (clearing),
		.rsp      (rsp)
	);

endmodule
